FILE: src/joystick_to_pwm_channel_mapper_core_macros.svh
// assertion macros used by the checker file
`ifndef JOYSTICK_TO_PWM_CHANNEL_MAPPER_CORE_MACROS_SVH
`define JOYSTICK_TO_PWM_CHANNEL_MAPPER_CORE_MACROS_SVH

// condition that holds at every edge outside reset
`define JPM_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies another in the next
`define JPM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/jpm_pkg.sv
// types and constants of the joystick to pwm channel mapper
`timescale 1ns / 1ps

package jpm_pkg;

  localparam int MAX_AXES_DEF    = 8;
  localparam int MAX_BUTTONS_DEF = 16;

  localparam logic [10:0] PULSE_MIN      = 11'd1000;
  localparam logic [10:0] PULSE_MAX      = 11'd2000;
  localparam logic [10:0] PULSE_CENTER   = 11'd1500;
  localparam logic [9:0]  PULSE_HALFSPAN = 10'd500;
  localparam logic [15:0] AXIS_FULL_SCALE = 16'd32767;
  localparam logic [15:0] IDLE_SAT       = 16'hFFFF;

  localparam logic [3:0]  AXIS_COUNT_RST   = 4'd8;
  localparam logic [4:0]  BUTTON_COUNT_RST = 5'd16;
  localparam logic [15:0] TIMEOUT_RST      = 16'd300;

  localparam logic [6:0] EV_BUTTON = 7'd1;
  localparam logic [6:0] EV_AXIS   = 7'd2;

  typedef enum logic [1:0] {
    REG_AXIS_COUNT   = 2'd0,
    REG_BUTTON_COUNT = 2'd1,
    REG_TIMEOUT_MS   = 2'd2
  } jpm_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } jpm_state_t;

endpackage

FILE: src/jpm_axis_scale.sv
// axis position to pulse width scaler, registered multiply stage then division by full scale
`timescale 1ns / 1ps

module jpm_axis_scale import jpm_pkg::*; (
  input  logic               clk,
  input  logic               mul_en,
  input  logic signed [15:0] value,
  output logic [10:0]        pulse_us
);

  logic [16:0] mag;
  logic [23:0] prod_nxt;
  logic [23:0] prod_r;
  logic        neg_r;
  logic [8:0]  hi;
  logic [15:0] rem_sum;
  logic [8:0]  quot;

  assign mag      = value[15] ? (17'd0 - {value[15], value}) : {1'b0, value};
  assign prod_nxt = {7'd0, mag} * {14'd0, PULSE_HALFSPAN};

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
      neg_r  <= value[15];
    end
  end

  // x / 32767 = hi + (hi + lo) / 32767, and hi + lo stays below twice the divisor
  assign hi      = prod_r[23:15];
  assign rem_sum = {7'd0, hi} + {1'b0, prod_r[14:0]};
  assign quot    = (rem_sum >= AXIS_FULL_SCALE) ? (hi + 9'd1) : hi;

  assign pulse_us = neg_r ? (PULSE_CENTER - {2'd0, quot}) : (PULSE_CENTER + {2'd0, quot});

endmodule

FILE: src/joystick_to_pwm_channel_mapper_core.sv
// joystick to pwm channel mapper, top level with sequencer and channel store
// button event result is valid the cycle after accept; axis events first pass ST_MUL, ST_DIV
// sweep: each axis passes ST_LOAD, ST_MUL and ST_DIV through the shared scaler, each button
// only ST_LOAD, then ST_EMIT per channel, which holds on output stall; a tick without sweep
// stays in ST_IDLE; input is stalled from accept until the last result of the item is taken
// synchronous reset restores register defaults, zeroes stored channels and the idle count
`timescale 1ns / 1ps

module joystick_to_pwm_channel_mapper_core import jpm_pkg::*; #(
  parameter int MAX_AXES    = MAX_AXES_DEF,
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_event_type,
  input  logic [7:0]         in_event_number,
  input  logic signed [15:0] in_event_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_channel,
  output logic [10:0]        out_pulse_us,
  output logic               out_is_repeat,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int AIW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int BIW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int CW  = $clog2(MAX_AXES + MAX_BUTTONS + 1);

  jpm_state_t state_r, state_nxt;

  logic [3:0]               axis_count_r;
  logic [4:0]               button_count_r;
  logic [15:0]              timeout_r;
  logic [15:0]              idle_r;
  logic signed [15:0]       axis_values_r [MAX_AXES];
  logic [MAX_BUTTONS-1:0]   button_r;

  logic signed [15:0]       val_r;
  logic [CW-1:0]            sweep_idx_r;
  logic [4:0]               out_channel_r;
  logic [10:0]              out_pulse_r;
  logic                     out_is_repeat_r;
  logic                     out_last_r;

  logic [3:0]    na;
  logic [4:0]    nb;
  logic [CW-1:0] total;
  logic          in_acc;
  logic          axis_hit;
  logic          btn_hit;
  logic [15:0]   idle_inc;
  logic          sweep_hit;
  logic          idx_is_axis;
  logic [CW-1:0] btn_idx;
  logic [CW-1:0] idx_next;
  logic          mul_en;
  logic [10:0]   scale_pulse;

  assign na = ({2'd0, axis_count_r} > 6'(MAX_AXES)) ? 4'(MAX_AXES) : axis_count_r;
  assign nb = ({2'd0, button_count_r} > 7'(MAX_BUTTONS)) ? 5'(MAX_BUTTONS) : button_count_r;
  assign total = CW'(na) + CW'(nb);

  assign in_acc    = in_valid && !in_stall;
  assign axis_hit  = (in_event_type[6:0] == EV_AXIS) && (in_event_number < 8'(na));
  assign btn_hit   = (in_event_type[6:0] == EV_BUTTON) && (in_event_number < 8'(nb));
  assign idle_inc  = (idle_r != IDLE_SAT) ? (idle_r + 16'd1) : idle_r;
  assign sweep_hit = idle_inc > timeout_r;

  assign idx_is_axis = sweep_idx_r < CW'(na);
  assign btn_idx     = sweep_idx_r - CW'(na);
  assign idx_next    = sweep_idx_r + CW'(1);

  jpm_axis_scale u_scale (
    .clk      (clk),
    .mul_en   (mul_en),
    .value    (val_r),
    .pulse_us (scale_pulse)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_req_type) begin
            if (axis_hit) begin
              state_nxt = ST_MUL;
            end else if (btn_hit) begin
              state_nxt = ST_EMIT;
            end
          end else if (sweep_hit && (total != '0)) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: state_nxt = idx_is_axis ? ST_MUL : ST_EMIT;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_stall) begin
          state_nxt = (out_is_repeat_r && !out_last_r) ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    mul_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall  = 1'b0;
      ST_LOAD: in_stall  = 1'b1;
      ST_MUL:  mul_en    = 1'b1;
      ST_DIV:  in_stall  = 1'b1;
      ST_EMIT: out_valid = 1'b1;
      default: in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      axis_count_r   <= AXIS_COUNT_RST;
      button_count_r <= BUTTON_COUNT_RST;
      timeout_r      <= TIMEOUT_RST;
      idle_r         <= '0;
      axis_values_r  <= '{default: '0};
      button_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (jpm_reg_t'(cfg_index))
          REG_AXIS_COUNT:   axis_count_r   <= cfg_wdata[3:0];
          REG_BUTTON_COUNT: button_count_r <= cfg_wdata[4:0];
          REG_TIMEOUT_MS:   timeout_r      <= cfg_wdata;
          default:          timeout_r      <= timeout_r;
        endcase
      end
      if ((state_r == ST_IDLE) && in_acc) begin
        if (!in_req_type) begin
          idle_r <= '0;
          if (axis_hit) begin
            axis_values_r[in_event_number[AIW-1:0]] <= in_event_value;
          end else if (btn_hit) begin
            button_r[in_event_number[BIW-1:0]] <= (in_event_value != 16'sd0);
          end
        end else begin
          idle_r <= sweep_hit ? 16'd0 : idle_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          val_r           <= in_event_value;
          sweep_idx_r     <= '0;
          out_is_repeat_r <= 1'b0;
          out_last_r      <= 1'b1;
          out_channel_r   <= axis_hit ? in_event_number[4:0]
                                      : (5'(na) + in_event_number[4:0]);
          out_pulse_r     <= (in_event_value != 16'sd0) ? PULSE_MAX : PULSE_MIN;
        end
      end
      ST_LOAD: begin
        out_channel_r   <= 5'(sweep_idx_r);
        out_is_repeat_r <= 1'b1;
        out_last_r      <= (idx_next == total);
        if (idx_is_axis) begin
          val_r <= axis_values_r[sweep_idx_r[AIW-1:0]];
        end else begin
          out_pulse_r <= button_r[btn_idx[BIW-1:0]] ? PULSE_MAX : PULSE_MIN;
        end
      end
      ST_DIV: out_pulse_r <= scale_pulse;
      ST_EMIT: begin
        if (!out_stall) begin
          sweep_idx_r <= idx_next;
        end
      end
      default: out_last_r <= out_last_r;
    endcase
  end

  assign out_channel   = out_channel_r;
  assign out_pulse_us  = out_pulse_r;
  assign out_is_repeat = out_is_repeat_r;
  assign out_last      = out_last_r;

endmodule

FILE: src/jpm_chk.sv
// port level checker for the joystick to pwm channel mapper, bound to the top level
`timescale 1ns / 1ps
`include "joystick_to_pwm_channel_mapper_core_macros.svh"

module jpm_chk import jpm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_channel,
  input logic [10:0] out_pulse_us,
  input logic        out_is_repeat,
  input logic        out_last
);

  `JPM_ASSERT_NOW(a_pulse_range, !out_valid || ((out_pulse_us >= PULSE_MIN) && (out_pulse_us <= PULSE_MAX)), "pulse width out of range")
  `JPM_ASSERT_NOW(a_event_single, !out_valid || out_is_repeat || out_last, "event result not flagged last")
  `JPM_ASSERT_NOW(a_busy_while_emit, !out_valid || in_stall, "input taken while a result is pending")
  `JPM_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "result dropped while stalled")
  `JPM_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(out_channel) && $stable(out_pulse_us), "stalled result changed")

endmodule

bind joystick_to_pwm_channel_mapper_core jpm_chk u_jpm_chk (.*);
